FILE: rtl/srsw_pkg.sv
// shared types and constants of the selective-repeat sender window
`timescale 1ns / 1ps
`default_nettype none
package srsw_pkg;

  localparam int SEQ_SPACE = 16;
  localparam int SEQ_W     = 4;
  localparam int CNT_W     = 4;
  localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(SEQ_SPACE / 2);
  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(4);

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_SLIDE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/selective_repeat_sender_window.sv
// selective-repeat sender window bookkeeping with a shared subtract/compare unit
`timescale 1ns / 1ps
`default_nettype none
// usage
//   request channel: drive in_operation, in_seq_in, in_checksum_ok and raise start;
//   the request is taken at a rising edge with start high and busy low
//   result channel: out_valid is high for exactly one cycle and the out_ ports
//   carry the result then; the receiver cannot hold results off
//   config channel: cfg_window_size is written when cfg_valid and cfg_ready are
//   both high; cfg_ready is always high, write only while the block is idle
// steps, from the accepting edge to the strobe cycle
//   send: check, strobe
//   timeout: offset, window compare, strobe
//   acknowledgement: offset, window compare, strobe, plus slide steps when it hits
//   the base and slides over acknowledged entries (at most the in-flight count)
//   a new request is taken in the strobe cycle, so requests can run back to back;
//   the pace is set by the one shared subtractor, used once per cycle, and the
//   single read port of the acknowledge marks, which the slide walks one entry a cycle
// reset (rst_n low, synchronous): base and next sequence go to 0, all marks clear,
//   window size goes to 4, the block goes idle
`default_nettype none
module selective_repeat_sender_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [srsw_pkg::SEQ_W-1:0] in_seq_in,
  input  wire logic                       in_checksum_ok,
  // result channel
  output      logic                       out_valid,
  output      logic [1:0]                 out_status,
  output      logic                       out_transmit,
  output      logic                       out_timer_start,
  output      logic                       out_timer_stop,
  output      logic [srsw_pkg::SEQ_W-1:0] out_seq_out,
  output      logic [srsw_pkg::SEQ_W-1:0] out_window_base,
  output      logic [srsw_pkg::CNT_W-1:0] out_in_flight,
  // config channel
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [srsw_pkg::CNT_W-1:0] cfg_window_size
);

  localparam int SW = srsw_pkg::SEQ_W;
  localparam int CW = srsw_pkg::CNT_W;

  srsw_pkg::state_t state_r, state_nxt;

  // window state
  logic [SW-1:0]                  base_r, base_nxt;
  logic [SW-1:0]                  next_r, next_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;      // next - base, kept as a count
  logic [srsw_pkg::SEQ_SPACE-1:0] mark_r, mark_nxt;
  logic [CW-1:0]                  ws_r, ws_nxt;

  // latched request
  logic [1:0]    op_r, op_nxt;
  logic [SW-1:0] seq_r, seq_nxt;
  logic          ok_r, ok_nxt;
  logic [SW-1:0] off_r, off_nxt;                       // seq - base

  // result registers
  logic [1:0]    status_r, status_nxt;
  logic          tx_r, tx_nxt;
  logic          tstart_r, tstart_nxt;
  logic          tstop_r, tstop_nxt;
  logic [SW-1:0] sout_r, sout_nxt;

  // shared subtract/compare unit
  logic [CW-1:0] alu_a, alu_b;
  logic [CW:0]   alu_diff;
  logic          alu_lt;

  logic [CW-1:0] win;
  logic          accept;
  logic [SW-1:0] mark_addr;
  logic          mark_rd;

  assign accept = start && !busy;
  assign win    = (ws_r > srsw_pkg::WIN_MAX) ? srsw_pkg::WIN_MAX : ws_r;

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt   = alu_diff[CW];

  // one mark read a cycle: the request's entry in compare, the base while sliding
  assign mark_addr = (state_r == srsw_pkg::S_SLIDE) ? base_r : seq_r;
  assign mark_rd   = mark_r[mark_addr];

  // operand selection for the shared unit
  always_comb begin
    alu_a = cnt_r;
    alu_b = win;
    unique case (state_r)
      srsw_pkg::S_CHECK: begin
        if (op_r == srsw_pkg::OP_SEND) begin
          alu_a = cnt_r;
          alu_b = win;
        end else begin
          alu_a = CW'(seq_r);
          alu_b = CW'(base_r);
        end
      end
      srsw_pkg::S_CMP: begin
        alu_a = CW'(off_r);
        alu_b = cnt_r;
      end
      srsw_pkg::S_SLIDE: begin
        alu_a = cnt_r;
        alu_b = CW'(1);
      end
      default: begin
        alu_a = cnt_r;
        alu_b = win;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srsw_pkg::S_IDLE: begin
        if (accept) state_nxt = srsw_pkg::S_CHECK;
      end
      srsw_pkg::S_CHECK: begin
        if (op_r == srsw_pkg::OP_ACK || op_r == srsw_pkg::OP_TIMEOUT) begin
          state_nxt = srsw_pkg::S_CMP;
        end else begin
          state_nxt = srsw_pkg::S_DONE;
        end
      end
      srsw_pkg::S_CMP: begin
        // an accepted ack at the base starts the slide
        if (op_r == srsw_pkg::OP_ACK && ok_r && alu_lt && off_r == '0) begin
          state_nxt = srsw_pkg::S_SLIDE;
        end else begin
          state_nxt = srsw_pkg::S_DONE;
        end
      end
      srsw_pkg::S_SLIDE: begin
        if (cnt_r == '0 || !mark_rd) state_nxt = srsw_pkg::S_DONE;
      end
      srsw_pkg::S_DONE: begin
        state_nxt = accept ? srsw_pkg::S_CHECK : srsw_pkg::S_IDLE;
      end
      default: state_nxt = srsw_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      srsw_pkg::S_IDLE: busy = 1'b0;
      srsw_pkg::S_DONE: begin
        busy      = 1'b0;
        out_valid = 1'b1;
      end
      default: begin
        busy      = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // datapath updates
  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    cnt_nxt    = cnt_r;
    mark_nxt   = mark_r;
    ws_nxt     = ws_r;
    op_nxt     = op_r;
    seq_nxt    = seq_r;
    ok_nxt     = ok_r;
    off_nxt    = off_r;
    status_nxt = status_r;
    tx_nxt     = tx_r;
    tstart_nxt = tstart_r;
    tstop_nxt  = tstop_r;
    sout_nxt   = sout_r;

    if (cfg_valid && cfg_ready) ws_nxt = cfg_window_size;

    if (accept) begin
      op_nxt  = in_operation;
      seq_nxt = in_seq_in;
      ok_nxt  = in_checksum_ok;
    end

    case (state_r)
      srsw_pkg::S_CHECK: begin
        // default result: ignored, echo the sequence number
        status_nxt = srsw_pkg::STAT_IGNORED;
        tx_nxt     = 1'b0;
        tstart_nxt = 1'b0;
        tstop_nxt  = 1'b0;
        sout_nxt   = seq_r;
        off_nxt    = alu_diff[SW-1:0];
        if (op_r == srsw_pkg::OP_SEND) begin
          if (alu_lt) begin
            status_nxt       = srsw_pkg::STAT_OK;
            tx_nxt           = 1'b1;
            tstart_nxt       = 1'b1;
            sout_nxt         = next_r;
            mark_nxt[next_r] = 1'b0;
            next_nxt         = next_r + SW'(1);
            cnt_nxt          = cnt_r + CW'(1);
          end else begin
            status_nxt = srsw_pkg::STAT_FULL;
            sout_nxt   = '0;
          end
        end
      end
      srsw_pkg::S_CMP: begin
        // alu_lt: offset from base lies below the in-flight count
        if (op_r == srsw_pkg::OP_ACK) begin
          if (ok_r && alu_lt) begin
            status_nxt      = srsw_pkg::STAT_OK;
            tstop_nxt       = 1'b1;
            mark_nxt[seq_r] = 1'b1;
          end
        end else if (alu_lt && !mark_rd) begin
          status_nxt = srsw_pkg::STAT_OK;
          tx_nxt     = 1'b1;
          tstart_nxt = 1'b1;
          tstop_nxt  = 1'b1;
        end
      end
      srsw_pkg::S_SLIDE: begin
        if (cnt_r != '0 && mark_rd) begin
          mark_nxt[base_r] = 1'b0;
          base_nxt         = base_r + SW'(1);
          cnt_nxt          = alu_diff[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srsw_pkg::S_IDLE;
      base_r  <= '0;
      next_r  <= '0;
      cnt_r   <= '0;
      mark_r  <= '0;
      ws_r    <= srsw_pkg::WIN_RESET;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
      ws_r    <= ws_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    seq_r    <= seq_nxt;
    ok_r     <= ok_nxt;
    off_r    <= off_nxt;
    status_r <= status_nxt;
    tx_r     <= tx_nxt;
    tstart_r <= tstart_nxt;
    tstop_r  <= tstop_nxt;
    sout_r   <= sout_nxt;
  end

  assign out_status      = status_r;
  assign out_transmit    = tx_r;
  assign out_timer_start = tstart_r;
  assign out_timer_stop  = tstop_r;
  assign out_seq_out     = sout_r;
  assign out_window_base = base_r;
  assign out_in_flight   = cnt_r;

  // in-flight count never exceeds half the sequence space
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= srsw_pkg::WIN_MAX)
    else $error("in-flight count above window limit");

  // one strobe per request, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a taken request always keeps the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking a request");

  // next sequence always equals base plus the in-flight count
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    next_r == SW'(base_r + SW'(cnt_r)))
    else $error("in-flight count out of step with base and next");

endmodule
`default_nettype wire
